### src/float_to_sci_display_digits_assert.svh
// Assertion macros shared by the display formatter RTL.
`ifndef FLOAT_TO_SCI_DISPLAY_DIGITS_ASSERT_SVH
`define FLOAT_TO_SCI_DISPLAY_DIGITS_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fsd assertion failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define FSD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fsd assertion failed");

`endif

### src/fsd_pkg.sv
// Package with constants, types and the rounding function of the display formatter.
`default_nettype none
package fsd_pkg;

  // Display geometry.
  localparam int MANTISSA_DIGITS = 6;
  localparam int EXPONENT_DIGITS = 2;
  localparam int BCD_W           = 4 * MANTISSA_DIGITS;
  localparam int DCNT_W          = $clog2(MANTISSA_DIGITS);
  localparam int SCALE_LIMIT     = 34;

  // Magnitude bit patterns (sign removed) of the single precision range bounds.
  localparam logic [30:0] UPPER_MAG = 31'h497423F0;  // 999999.0
  localparam logic [30:0] LOWER_MAG = 31'h47C35000;  // 100000.0
  localparam logic [30:0] CENTI_MAG = 31'h3C23D70A;  // 0.01
  localparam logic [30:0] ONE_MAG   = 31'h3F800000;  // 1.0
  localparam logic [30:0] EXP_ALL1  = 31'h7F800000;

  // Multiplier constants.
  localparam logic [31:0] RECIP_5  = 32'hCCCCCCCD;  // with >>34 gives x/5
  localparam logic [31:0] TEN      = 32'd10;
  localparam logic [31:0] FRAC_MUL = 32'd1000000;

  // Exponent bias plus mantissa width: value = m * 2^(B - EXP_OFS).
  localparam logic [7:0] EXP_OFS = 8'd150;

  // Magnitude ranges.
  typedef enum logic [3:0] {
    RNG_LARGE = 4'b0001,
    RNG_SMALL = 4'b0010,
    RNG_MID   = 4'b0100,
    RNG_FRAC  = 4'b1000
  } fsd_range_t;

  // Round a product (p + sticky part) * 2^(eb - 150) to a single precision
  // magnitude, nearest even. A product below 2^23 is an exact subnormal.
  function automatic logic [30:0] fsd_round(input logic [27:0] p, input logic sticky,
                                            input logic [9:0] eb);
    logic [2:0]  sh;
    logic [23:0] m;
    logic        g;
    logic        rest;
    logic [24:0] m1;
    logic [9:0]  be;
    if (p[27:23] == 5'd0) return {8'd0, p[22:0]};
    priority if (p[27]) begin
      sh = 3'd4; m = p[27:4]; g = p[3]; rest = |p[2:0];
    end else if (p[26]) begin
      sh = 3'd3; m = p[26:3]; g = p[2]; rest = |p[1:0];
    end else if (p[25]) begin
      sh = 3'd2; m = p[25:2]; g = p[1]; rest = p[0];
    end else if (p[24]) begin
      sh = 3'd1; m = p[24:1]; g = p[0]; rest = 1'b0;
    end else begin
      sh = 3'd0; m = p[23:0]; g = 1'b0; rest = 1'b0;
    end
    rest = rest | sticky;
    m1   = {1'b0, m} + 25'(g & (rest | m[0]));
    be   = eb + 10'(sh);
    if (m1[24]) begin
      be = be + 10'd1;
      m1 = m1 >> 1;
    end
    return {be[7:0], m1[22:0]};
  endfunction

endpackage
`default_nettype wire

### src/fsd_if.sv
// Valid/ready channel interfaces for the input value and the display result.
`default_nettype none
interface fsd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fsd_out_if;
  logic        valid;
  logic        ready;
  logic        negative;
  logic [23:0] digits_bcd;
  logic [2:0]  point_position;
  logic        exp_negative;
  logic [5:0]  exp_value;
  logic        exp_shown;
  logic        invalid;
  modport source (output valid, output negative, output digits_bcd, output point_position,
                  output exp_negative, output exp_value, output exp_shown, output invalid,
                  input ready);
  modport sink   (input valid, input negative, input digits_bcd, input point_position,
                  input exp_negative, input exp_value, input exp_shown, input invalid,
                  output ready);
endinterface
`default_nettype wire

### src/float_to_sci_display_digits.sv
// Calculator display formatter: single precision word in, six-digit display out.
//
// in_s carries one 32-bit single precision word; out_m returns one display
// word per input: sign, six packed BCD digits, point position, exponent sign,
// exponent magnitude, exponent-shown flag and an invalid flag for NaN or
// infinity. Both channels use valid/ready; a word moves when both are high.
// The block works on one word at a time: in_s.ready is high only when idle.
// One 32x32 multiplier is shared by every scaling step and digit extraction:
// a scaling step is a multiply state (ST_MUL) then a round state (ST_RND),
// and each digit a multiply state (ST_DMUL) then a subtract state (ST_DSUB).
// A word takes 0 to 34 scaling steps before its digits are extracted; NaN
// and infinity go from classification straight to the result. The result is
// held in registers until out_m.ready is seen, and a stalled receiver keeps
// the block from taking the next word.
// Synchronous reset returns the sequencer to idle with no result pending.
`default_nettype none
module float_to_sci_display_digits (
  input wire logic clk,
  input wire logic rst_n,
  fsd_in_if.sink   in_s,
  fsd_out_if.source out_m
);
  import fsd_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLASS = 8'b0000_0010,
    ST_MUL   = 8'b0000_0100,
    ST_RND   = 8'b0000_1000,
    ST_TRUNC = 8'b0001_0000,
    ST_DMUL  = 8'b0010_0000,
    ST_DSUB  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  fsd_range_t        range_r, range_nxt;
  logic              neg_r, neg_nxt;
  logic              inv_r, inv_nxt;
  logic [30:0]       mag_r, mag_nxt;
  logic signed [6:0] ex_r, ex_nxt;
  logic [2:0]        point_r, point_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [23:0]       ni_r, ni_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  // Fields of the current magnitude.
  logic [7:0]  bexp;
  logic [7:0]  bexp_s;
  logic [23:0] mant;
  assign bexp   = mag_r[30:23];
  assign bexp_s = (bexp == 8'd0) ? 8'd1 : bexp;
  assign mant   = {(bexp != 8'd0), mag_r[22:0]};

  // Shared multiplier operand selection.
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = {8'd0, mant};
    mul_b = TEN;
    if (state_r == ST_DMUL) begin
      mul_a = {8'd0, ni_r};
      mul_b = RECIP_5;
    end else begin
      unique case (range_r)
        RNG_LARGE: begin
          mul_a = {2'd0, mant, 6'd0};
          mul_b = RECIP_5;
        end
        RNG_FRAC:  mul_b = FRAC_MUL;
        RNG_SMALL,
        RNG_MID:   mul_b = TEN;
        default:   mul_b = TEN;
      endcase
    end
  end

  // Rounding of the registered product back to single precision.
  logic [27:0] quo;
  logic [29:0] quo5;
  logic [27:0] rp;
  logic        rsticky;
  logic [9:0]  reb;
  logic [30:0] rmag;
  assign quo  = prod_r[61:34];
  assign quo5 = {quo, 2'b00} + {2'b00, quo};
  always_comb begin
    rp      = prod_r[27:0];
    rsticky = 1'b0;
    reb     = {2'd0, bexp_s};
    unique case (range_r)
      RNG_LARGE: begin
        rp      = quo;
        rsticky = (quo5 != {mant, 6'd0});
        reb     = {2'd0, bexp_s} - 10'd7;
      end
      RNG_FRAC: begin
        rp      = prod_r[43:16];
        rsticky = |prod_r[15:0];
        reb     = {2'd0, bexp_s} + 10'd16;
      end
      RNG_SMALL,
      RNG_MID: begin
        rp      = prod_r[27:0];
        rsticky = 1'b0;
        reb     = {2'd0, bexp_s};
      end
      default: begin
        rp      = prod_r[27:0];
        rsticky = 1'b0;
        reb     = {2'd0, bexp_s};
      end
    endcase
    rmag = fsd_round(rp, rsticky, reb);
  end

  // Truncation of the scaled magnitude to an integer; it stays below 2^24.
  logic [7:0]  rshift;
  logic [23:0] trunc_val;
  assign rshift    = EXP_OFS - bexp_s;
  assign trunc_val = (rshift > 8'd23) ? 24'd0 : (mant >> rshift[4:0]);

  // One decimal digit from the reciprocal product.
  logic [23:0] dq;
  logic [26:0] dq10;
  logic [3:0]  digit;
  assign dq    = prod_r[58:35];
  assign dq10  = {dq, 3'b000} + {2'b00, dq, 1'b0};
  assign digit = 4'(ni_r - dq10[23:0]);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    range_nxt = range_r;
    neg_nxt   = neg_r;
    inv_nxt   = inv_r;
    mag_nxt   = mag_r;
    ex_nxt    = ex_r;
    point_nxt = point_r;
    prod_nxt  = prod_r;
    ni_nxt    = ni_r;
    bcd_nxt   = bcd_r;
    dcnt_nxt  = dcnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_s.valid) begin
          mag_nxt   = in_s.value[30:0];
          neg_nxt   = in_s.value[31] && (in_s.value[30:0] != 31'd0);
          ex_nxt    = 7'sd0;
          dcnt_nxt  = '0;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        inv_nxt = ((mag_r & EXP_ALL1) == EXP_ALL1);
        if ((mag_r & EXP_ALL1) == EXP_ALL1) begin
          state_nxt = ST_DONE;
        end else if (mag_r > UPPER_MAG) begin
          range_nxt = RNG_LARGE;
          point_nxt = 3'(MANTISSA_DIGITS - 1);
          state_nxt = ST_MUL;
        end else if (mag_r < CENTI_MAG) begin
          range_nxt = RNG_SMALL;
          point_nxt = 3'(MANTISSA_DIGITS - 1);
          state_nxt = ST_MUL;
        end else if (mag_r >= ONE_MAG) begin
          range_nxt = RNG_MID;
          point_nxt = 3'd0;
          state_nxt = (mag_r < LOWER_MAG) ? ST_MUL : ST_TRUNC;
        end else begin
          range_nxt = RNG_FRAC;
          point_nxt = 3'(MANTISSA_DIGITS);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        mag_nxt = rmag;
        unique case (range_r)
          RNG_LARGE: begin
            ex_nxt    = ex_r + 7'sd1;
            state_nxt = ((rmag > UPPER_MAG) && (ex_r < 7'(SCALE_LIMIT - 1))) ?
                        ST_MUL : ST_TRUNC;
          end
          RNG_SMALL: begin
            ex_nxt    = ex_r - 7'sd1;
            state_nxt = ((rmag < LOWER_MAG) && (ex_r > -7'(SCALE_LIMIT - 1))) ?
                        ST_MUL : ST_TRUNC;
          end
          RNG_MID: begin
            point_nxt = point_r + 3'd1;
            state_nxt = (rmag < LOWER_MAG) ? ST_MUL : ST_TRUNC;
          end
          RNG_FRAC: state_nxt = ST_TRUNC;
          default:  state_nxt = ST_TRUNC;
        endcase
      end
      ST_TRUNC: begin
        ni_nxt = trunc_val;
        if (range_r == RNG_LARGE || range_r == RNG_SMALL) begin
          ex_nxt = ex_r + 7'(MANTISSA_DIGITS - 1);
        end
        state_nxt = ST_DMUL;
      end
      ST_DMUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_DSUB;
      end
      ST_DSUB: begin
        // Least significant digit first; it ends up in the low nibble.
        bcd_nxt  = {digit, bcd_r[BCD_W-1:4]};
        ni_nxt   = dq;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(MANTISSA_DIGITS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DMUL;
        end
      end
      ST_DONE: begin
        if (out_m.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      range_r <= RNG_MID;
      inv_r   <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      range_r <= range_nxt;
      inv_r   <= inv_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    ex_r    <= ex_nxt;
    point_r <= point_nxt;
    prod_r  <= prod_nxt;
    ni_r    <= ni_nxt;
    bcd_r   <= bcd_nxt;
  end

  // Result word; the exponent never exceeds 39, so it fits two digits as is.
  logic [6:0] ex_mag;
  assign ex_mag = ex_r[6] ? 7'(-ex_r) : 7'(ex_r);

  assign in_s.ready           = (state_r == ST_IDLE);
  assign out_m.valid          = (state_r == ST_DONE);
  assign out_m.invalid        = inv_r;
  assign out_m.negative       = neg_r & ~inv_r;
  assign out_m.digits_bcd     = inv_r ? '0 : bcd_r;
  assign out_m.point_position = inv_r ? 3'd0 : point_r;
  assign out_m.exp_negative   = ~inv_r & ex_r[6];
  assign out_m.exp_shown      = ~inv_r & (ex_r != 7'sd0);
  assign out_m.exp_value      = inv_r ? 6'd0 : ex_mag[5:0];

  // Fields that an invalid word leaves at zero, and the last digit step.
  logic inv_fields_zero;
  logic last_digit;
  assign inv_fields_zero = (out_m.digits_bcd == '0) && !out_m.exp_shown && !out_m.negative;
  assign last_digit      = (state_r == ST_DSUB) && (dcnt_r == DCNT_W'(MANTISSA_DIGITS - 1));

  `include "float_to_sci_display_digits_assert.svh"

  `FSD_ASSERT_ALWAYS(a_no_overlap, !(in_s.ready && out_m.valid))
  `FSD_ASSERT_ALWAYS(a_inv_clean, !(out_m.valid && out_m.invalid) || inv_fields_zero)
  `FSD_ASSERT_ALWAYS(a_blank_exp, !out_m.valid || out_m.exp_shown || (out_m.exp_value == 6'd0 && !out_m.exp_negative))
  `FSD_ASSERT_NEXT(a_digit_loop, last_digit, state_r == ST_DONE)

endmodule
`default_nettype wire

### tb/sv/float_to_sci_display_digits_tb.sv
// Self-checking testbench for the single precision to calculator display formatter.
`default_nettype none
module float_to_sci_display_digits_tb;
  import fsd_pkg::*;

  // One display word as the block presents it.
  typedef struct packed {
    logic        negative;
    logic [23:0] digits_bcd;
    logic [2:0]  point_position;
    logic        exp_negative;
    logic [5:0]  exp_value;
    logic        exp_shown;
    logic        invalid;
  } display_t;

  // A directed row: an input word, and a typed display where one is obvious.
  typedef struct {
    logic [31:0] value;
    bit          typed;
    display_t    shown;
  } probe_t;

  localparam int RANDOM_WORDS = 500;
  localparam int STALL_LIMIT  = 5000;
  localparam display_t INVALID_DISP = '{invalid: 1'b1, default: '0};
  // Zero runs every scaling step: exponent 5 - 34 = -29, digits all zero.
  localparam display_t ZERO_DISP = '{negative: 1'b0, digits_bcd: 24'h0, point_position: 3'd5,
                                     exp_negative: 1'b1, exp_value: 6'd29, exp_shown: 1'b1,
                                     invalid: 1'b0};

  logic clk;
  logic rst_n;
  fsd_in_if  in_if ();
  fsd_out_if out_if ();

  float_to_sci_display_digits dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_m (out_if)
  );

  display_t pending_displays[$];
  int       mismatches = 0;
  int       words_checked = 0;
  int       invalid_seen = 0;
  int       idle_cycles = 0;
  bit       calm = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round (n / (div5 ? 5 : 1)) * 2^e to a single precision magnitude, nearest even.
  function automatic logic [30:0] round_single(input logic [63:0] n, input int e,
                                               input bit div5);
    logic [63:0] q;
    logic [63:0] kept;
    bit          sticky;
    bit          guard;
    bit          rest;
    int          msb;
    int          shift;
    int          lsb_exp;
    q = n;
    sticky = 0;
    guard = 0;
    rest = 0;
    msb = 0;
    if (n == 0) return '0;
    if (div5) begin
      q = (n << 32) / 5;
      sticky = ((n << 32) % 5) != 0;
      e = e - 32;
    end
    for (int i = 0; i < 64; i++) if (q[i]) msb = i;
    shift = msb - 23;
    if (-149 - e > shift) shift = -149 - e;
    if (shift > 0) begin
      kept = q >> shift;
      guard = q[shift-1];
      rest = sticky || ((q & ((64'd1 << (shift - 1)) - 1)) != 0);
    end else begin
      kept = q << (-shift);
    end
    if (guard && (rest || kept[0])) kept = kept + 1;
    lsb_exp = e + shift;
    if (kept[24]) begin
      kept = kept >> 1;
      lsb_exp++;
    end
    if (kept < 64'h800000) return {8'd0, kept[22:0]};
    return {8'(lsb_exp + 150), kept[22:0]};
  endfunction

  // Multiply a magnitude by k, or divide it by ten, rounding once to single precision.
  function automatic logic [30:0] rescale(input logic [30:0] mag, input int k, input bit by_ten);
    logic [63:0] m;
    int          e;
    m = {41'd0, (mag[30:23] != 0), mag[22:0]};
    e = (mag[30:23] == 0) ? -149 : int'(mag[30:23]) - 150;
    if (by_ten) return round_single(m, e - 1, 1'b1);
    return round_single(m * k, e, 1'b0);
  endfunction

  // Work out the display that a single precision word should produce.
  function automatic display_t display_of(input logic [31:0] word);
    display_t    d;
    logic [30:0] mag;
    logic [63:0] m;
    logic [63:0] whole;
    int          e;
    int          ex;
    int          pt;
    d = '0;
    mag = word[30:0];
    ex = 0;
    pt = 0;
    if (mag[30:23] == 8'hFF) return INVALID_DISP;
    d.negative = word[31] && (mag != 0);
    if (mag > UPPER_MAG) begin
      while (mag > UPPER_MAG && ex < SCALE_LIMIT) begin
        mag = rescale(mag, 0, 1'b1);
        ex++;
      end
      pt = MANTISSA_DIGITS - 1;
      ex += pt;
    end else if (mag < CENTI_MAG) begin
      while (mag < LOWER_MAG && ex > -SCALE_LIMIT) begin
        mag = rescale(mag, 10, 1'b0);
        ex--;
      end
      pt = MANTISSA_DIGITS - 1;
      ex += pt;
    end else if (mag >= ONE_MAG) begin
      while (mag < LOWER_MAG) begin
        mag = rescale(mag, 10, 1'b0);
        pt++;
      end
    end else begin
      mag = rescale(mag, 1000000, 1'b0);
      pt = MANTISSA_DIGITS;
    end
    // Truncate the scaled magnitude to an integer and keep its low six digits.
    m = {41'd0, (mag[30:23] != 0), mag[22:0]};
    e = (mag[30:23] == 0) ? -149 : int'(mag[30:23]) - 150;
    whole = (e >= 0) ? (m << e) : (m >> (-e));
    if (whole > 64'hFFFFFFFF) whole = 64'hFFFFFFFF;
    for (int i = 0; i < MANTISSA_DIGITS; i++) begin
      d.digits_bcd[4*i +: 4] = 4'(whole % 10);
      whole = whole / 10;
    end
    d.point_position = 3'(pt);
    if (ex < 0) begin
      d.exp_negative = 1'b1;
      ex = -ex;
    end
    if (ex > 0) begin
      d.exp_shown = 1'b1;
      d.exp_value = 6'(ex % 100);
    end
    return d;
  endfunction

  // Gap length before the next word or between ready pulses: mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random word, biased toward the display ranges and their boundaries.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5, 6: w[30:23] = 8'($urandom_range(100, 160));
      7: w[30:23] = 8'($urandom_range(0, 20));
      8: begin
        case ($urandom_range(0, 3))
          0: w[30:0] = UPPER_MAG;
          1: w[30:0] = LOWER_MAG;
          2: w[30:0] = CENTI_MAG;
          default: w[30:0] = ONE_MAG;
        endcase
        w[30:0] = w[30:0] + 31'($urandom_range(0, 6)) - 31'd3;
      end
      default: w[30:23] = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(200, 254));
    endcase
    return w;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input logic [31:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= word;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Record the expected display for every word the block accepts.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) pending_displays.push_back(display_of(in_if.value));
  end

  // Receiver: random stalls on ready, and a check of every accepted display word.
  int stall_left = 0;
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        stall_left <= pick_gap();
        out_if.ready <= 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.negative, out_if.digits_bcd, out_if.point_position,
                out_if.exp_negative, out_if.exp_value, out_if.exp_shown, out_if.invalid};
        if (pending_displays.size() == 0) begin
          $display("%0t: display word with nothing expected: %h", $time, got);
          mismatches++;
        end else begin
          want = pending_displays.pop_front();
          words_checked++;
          if (want.invalid) invalid_seen++;
          if (got.negative !== want.negative)
            $display("%0t: negative expected %b actual %b", $time, want.negative, got.negative);
          if (got.digits_bcd !== want.digits_bcd)
            $display("%0t: digits_bcd expected %h actual %h", $time, want.digits_bcd,
                     got.digits_bcd);
          if (got.point_position !== want.point_position)
            $display("%0t: point_position expected %0d actual %0d", $time,
                     want.point_position, got.point_position);
          if (got.exp_negative !== want.exp_negative)
            $display("%0t: exp_negative expected %b actual %b", $time, want.exp_negative,
                     got.exp_negative);
          if (got.exp_value !== want.exp_value)
            $display("%0t: exp_value expected %0d actual %0d", $time, want.exp_value,
                     got.exp_value);
          if (got.exp_shown !== want.exp_shown)
            $display("%0t: exp_shown expected %b actual %b", $time, want.exp_shown,
                     got.exp_shown);
          if (got.invalid !== want.invalid)
            $display("%0t: invalid expected %b actual %b", $time, want.invalid, got.invalid);
          if (got !== want) mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress, %0d displays outstanding", $time, pending_displays.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Directed words, then random ones, then drain and report.
  initial begin
    probe_t probes[$];
    display_t typed_disp;
    probes = '{
      '{32'h0000_0000, 1, ZERO_DISP},
      '{32'h8000_0000, 1, ZERO_DISP},
      '{32'h7F80_0000, 1, INVALID_DISP},
      '{32'hFF80_0000, 1, INVALID_DISP},
      '{32'h7FC0_0000, 1, INVALID_DISP},
      '{32'hFFFF_FFFF, 1, INVALID_DISP},
      '{32'h7F80_0001, 1, INVALID_DISP},
      '{32'h3F80_0000, 0, '0},   // 1.0
      '{32'h4974_23F0, 0, '0},   // 999999.0, top of the unscaled range
      '{32'h4974_2400, 0, '0},   // 1000000.0, first value divided down
      '{32'h47C3_5000, 0, '0},   // 100000.0
      '{32'h3C23_D70A, 0, '0},   // 0.01
      '{32'h3C23_D709, 0, '0},   // just below 0.01
      '{32'h3F7F_FFFF, 0, '0},   // just below 1.0
      '{32'h3F00_0000, 0, '0},   // 0.5
      '{32'h7F7F_FFFF, 0, '0},   // largest finite
      '{32'hFF7F_FFFF, 0, '0},
      '{32'h0000_0001, 0, '0},   // smallest subnormal
      '{32'h8000_0001, 0, '0},
      '{32'h007F_FFFF, 0, '0},   // largest subnormal
      '{32'h0080_0000, 0, '0},   // smallest normal
      '{32'h4120_0000, 0, '0},   // 10.0
      '{32'hC2F6_E979, 0, '0},   // negative mid-range value
      '{32'h5368_D4A5, 0, '0}    // about 1e12
    };
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Typed rows must also agree with the predictor; check that up front.
    foreach (probes[i]) begin
      if (probes[i].typed) begin
        typed_disp = display_of(probes[i].value);
        if (typed_disp !== probes[i].shown) begin
          $display("%0t: word %h expected %h predicted %h", $time, probes[i].value,
                   probes[i].shown, typed_disp);
          mismatches++;
        end
      end
      send_word(probes[i].value);
    end

    // Random words, with stretches where neither side idles.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 50) calm = 1;
      if (i % 100 == 80) calm = 0;
      send_word(random_word());
    end
    in_if.valid <= 1'b0;

    while (pending_displays.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d display words, %0d of them NaN or infinity, across all four ranges,",
             words_checked, invalid_seen);
    $display("with random gaps and stalls on both channels.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
